// ===== rtl/core/elementwise_compare_to_bitmask_top_assert.svh =====
// Assertion macros used by the checker file
`ifndef ELEMENTWISE_COMPARE_TO_BITMASK_TOP_ASSERT_SVH
`define ELEMENTWISE_COMPARE_TO_BITMASK_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define ECB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define ECB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/ecb_pkg.sv =====
package ecb_pkg;

	localparam logic [1:0] OP_EQ = 2'd0;
	localparam logic [1:0] OP_LT = 2'd1;

	localparam logic [2:0] TY_I8  = 3'd0;
	localparam logic [2:0] TY_I16 = 3'd1;
	localparam logic [2:0] TY_I32 = 3'd2;
	localparam logic [2:0] TY_I64 = 3'd3;
	localparam logic [2:0] TY_F64 = 3'd4;

	localparam logic [2:0] REG_OP     = 3'd0;
	localparam logic [2:0] REG_LTYPE  = 3'd1;
	localparam logic [2:0] REG_RTYPE  = 3'd2;
	localparam logic [2:0] REG_USE    = 3'd3;
	localparam logic [2:0] REG_SLEFT  = 3'd4;
	localparam logic [2:0] REG_SVALUE = 3'd5;

	typedef struct packed {
		logic [63:0] left_bits;
		logic [63:0] right_bits;
		logic        last_element;
	} in_req_t;

	typedef struct packed {
		logic [63:0] mask_word;
		logic [6:0]  valid_bits;
		logic        last_word;
	} out_req_t;

	// classified request between front and back: ordered keys and flags
	typedef struct packed {
		logic [63:0] key_a;
		logic [63:0] key_b;
		logic        nan;
		logic        last;
	} cls_t;

	// sign-extend raw bits per type; unused codes give zero
	function automatic logic [63:0] load_int(input logic [63:0] raw, input logic [2:0] ty);
		logic [63:0] r;
		r = '0;
		unique case (ty)
			TY_I8:  r = {{56{raw[7]}}, raw[7:0]};
			TY_I16: r = {{48{raw[15]}}, raw[15:0]};
			TY_I32: r = {{32{raw[31]}}, raw[31:0]};
			TY_I64: r = raw;
			default: r = '0;
		endcase
		return r;
	endfunction

	// order-preserving key of a non-NaN double; -0 folds onto +0
	function automatic logic [63:0] f64_key(input logic [63:0] x);
		logic [63:0] y;
		y = (x[62:0] == '0) ? '0 : x;
		return y[63] ? ~y : (y | {1'b1, 63'd0});
	endfunction

endpackage

// ===== rtl/core/ecb_i2f.sv =====
// Integer to binary64 conversion, nearest even; two register stages
module ecb_i2f (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [63:0] f
);
	logic [63:0] mag;
	logic [5:0]  p;
	logic        sign_s1, zero_s1;
	logic [63:0] norm_s1;
	logic [5:0]  p_s1;
	logic [52:0] keep;
	logic        rnd;
	logic [53:0] sum;
	logic [10:0] expo;
	logic [63:0] f_s2;

	// leading one search (priority encoder)
	always_comb begin
		mag = v[63] ? (64'd0 - v) : v;
		p = '0;
		for (int i = 0; i < 64; i++)
			if (mag[i]) p = 6'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1 <= v[63];
			zero_s1 <= (mag == '0);
			norm_s1 <= mag << (6'd63 - p);
			p_s1    <= p;
		end
	end

	// round the normalised magnitude to 53 bits
	always_comb begin
		keep = norm_s1[63:11];
		rnd  = norm_s1[10] & ((norm_s1[9:0] != '0) | keep[0]);
		sum  = {1'b0, keep} + 54'(rnd);
		expo = 11'd1023 + 11'(p_s1) + 11'(sum[53]);
	end

	// second stage holds the packed double, aligned with the front's stage 2
	always_ff @(posedge clk) begin
		if (en)
			f_s2 <= zero_s1 ? '0 : {sign_s1, expo, sum[53] ? 52'd0 : sum[51:0]};
	end

	assign f = f_s2;
endmodule

// ===== rtl/core/ecb_front.sv =====
// Front: picks operands, converts integers, forms ordered keys.
// Two stages; advances whenever the queue has room.
module ecb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  ecb_pkg::in_req_t in_req,
	output logic             in_stall,
	input  logic [2:0]       ltype,
	input  logic [2:0]       rtype,
	input  logic             use_scalar,
	input  logic             scalar_on_left,
	input  logic [63:0]      scalar_value,
	input  logic             q_room,
	output logic             cls_valid,
	output ecb_pkg::cls_t    cls
);
	logic [63:0] lraw, rraw, li, ri, lf, rf;
	logic        adv, v_s1, v_s2, last_s1, last_s2;
	logic [63:0] lraw_s1, rraw_s1, lraw_s2, rraw_s2, a, b;
	logic        lfp, rfp;

	assign adv      = q_room;
	assign in_stall = !adv;
	assign lfp = (ltype == ecb_pkg::TY_F64);
	assign rfp = (rtype == ecb_pkg::TY_F64);

	// operand selection
	always_comb begin
		lraw = (use_scalar && scalar_on_left) ? scalar_value : in_req.left_bits;
		rraw = (use_scalar && !scalar_on_left) ? scalar_value : in_req.right_bits;
		li = ecb_pkg::load_int(lraw, ltype);
		ri = ecb_pkg::load_int(rraw, rtype);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lraw_s1 <= li;  rraw_s1 <= ri;  last_s1 <= in_req.last_element;
			lraw_s2 <= lraw_s1; rraw_s2 <= rraw_s1; last_s2 <= last_s1;
		end
	end

	// raw in stage 1 holds extended integers; double sides reread below
	logic [63:0] lsrc_s1, rsrc_s1, lsrc_s2, rsrc_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			lsrc_s1 <= lraw; rsrc_s1 <= rraw;
			lsrc_s2 <= lsrc_s1; rsrc_s2 <= rsrc_s1;
		end
	end

	ecb_i2f u_li2f (.clk(clk), .en(adv), .v(li), .f(lf));
	ecb_i2f u_ri2f (.clk(clk), .en(adv), .v(ri), .f(rf));

	// key formation at stage 2 output
	always_comb begin
		a = lfp ? lsrc_s2 : lf;
		b = rfp ? rsrc_s2 : rf;
		cls_valid = v_s2 && adv;
		cls.last  = last_s2;
		if (!lfp && !rfp) begin
			cls.key_a = lraw_s2 ^ {1'b1, 63'd0};
			cls.key_b = rraw_s2 ^ {1'b1, 63'd0};
			cls.nan   = 1'b0;
		end else begin
			cls.key_a = ecb_pkg::f64_key(a);
			cls.key_b = ecb_pkg::f64_key(b);
			cls.nan   = (a[62:0] > 63'h7FF0000000000000) ||
				(b[62:0] > 63'h7FF0000000000000);
		end
	end
endmodule

// ===== rtl/core/ecb_queue.sv =====
// Small FIFO between front and back
module ecb_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ecb_pkg::cls_t din,
	output logic          room,
	input  logic          pop,
	output logic          nempty,
	output ecb_pkg::cls_t dout
);
	localparam int AW = $clog2(DEPTH);
	ecb_pkg::cls_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	// three front requests may be in flight; keep that much room
	assign room   = (cnt_q + (AW+1)'(3)) <= (AW+1)'(DEPTH);
	assign nempty = cnt_q != '0;
	assign dout   = mem_q[rp_q];

	always_ff @(posedge clk) if (push) mem_q[wp_q] <= din;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/ecb_back.sv =====
// Back: applies the operator and packs bits into words
module ecb_back #(
	parameter int WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        compare_op,
	input  logic              q_nempty,
	input  ecb_pkg::cls_t     q_head,
	output logic              q_pop,
	output logic              out_valid,
	output ecb_pkg::out_req_t out_req,
	input  logic              out_stall
);
	localparam int PW = $clog2(WORD_BITS);
	logic [WORD_BITS-1:0] acc_q;
	logic [PW-1:0]        pos_q;
	logic                 hit, emit;
	logic [PW:0]          cnt;
	logic [WORD_BITS-1:0] nacc;

	assign q_pop = q_nempty && (!out_valid || !out_stall);

	always_comb begin
		case (compare_op)
			ecb_pkg::OP_EQ: hit = q_head.key_a == q_head.key_b;
			ecb_pkg::OP_LT: hit = q_head.key_a < q_head.key_b;
			default:        hit = q_head.key_a > q_head.key_b;
		endcase
		hit  = hit && !q_head.nan;
		nacc = acc_q | (WORD_BITS'(hit) << pos_q);
		cnt  = (PW+1)'(pos_q) + 1'b1;
		emit = (cnt == (PW+1)'(WORD_BITS)) || q_head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; pos_q <= '0; out_valid <= 1'b0;
		end else begin
			// a word is held while stalled, or loaded when one closes
			out_valid <= (q_pop && emit) || (out_valid && out_stall);
			if (q_pop) begin
				if (emit) begin
					acc_q <= '0; pos_q <= '0;
				end else begin
					acc_q <= nacc; pos_q <= cnt[PW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_req.mask_word  <= 64'(nacc);
			out_req.valid_bits <= 7'(cnt);
			out_req.last_word  <= q_head.last;
		end
	end
endmodule

// ===== rtl/core/elementwise_compare_to_bitmask_top.sv =====
// Element-wise compare to bitmask. One element pair is accepted per cycle
// unless stalled; a request passes a two-stage front (operand select, integer
// to double rounding, key forming), a four-entry queue and a back end that
// applies the operator and packs the result bit. A closing word is presented
// from the back end's output register. The input stalls while the queue holds
// two or more requests; the queue lets either side stall independently.
module elementwise_compare_to_bitmask_top #(
	parameter int WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  ecb_pkg::in_req_t  in_req,
	output logic              out_valid,
	input  logic              out_stall,
	output ecb_pkg::out_req_t out_req
);
	logic [1:0]  op_q;
	logic [2:0]  ltype_q, rtype_q;
	logic        use_q, sleft_q;
	logic [63:0] sval_q;
	logic        room, push, pop, nempty;
	ecb_pkg::cls_t cls, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0; ltype_q <= ecb_pkg::TY_I64; rtype_q <= ecb_pkg::TY_I64;
			use_q <= 1'b0; sleft_q <= 1'b0; sval_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ecb_pkg::REG_OP:     op_q    <= cfg_data[1:0];
				ecb_pkg::REG_LTYPE:  ltype_q <= cfg_data[2:0];
				ecb_pkg::REG_RTYPE:  rtype_q <= cfg_data[2:0];
				ecb_pkg::REG_USE:    use_q   <= cfg_data[0];
				ecb_pkg::REG_SLEFT:  sleft_q <= cfg_data[0];
				ecb_pkg::REG_SVALUE: sval_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ecb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_req(in_req),
		.in_stall(in_stall), .ltype(ltype_q), .rtype(rtype_q),
		.use_scalar(use_q), .scalar_on_left(sleft_q), .scalar_value(sval_q),
		.q_room(room), .cls_valid(push), .cls(cls)
	);

	ecb_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(cls), .room(room),
		.pop(pop), .nempty(nempty), .dout(head)
	);

	ecb_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .compare_op(op_q), .q_nempty(nempty),
		.q_head(head), .q_pop(pop), .out_valid(out_valid), .out_req(out_req),
		.out_stall(out_stall)
	);
endmodule

// ===== rtl/core/ecb_checker.sv =====
`include "elementwise_compare_to_bitmask_top_assert.svh"
// Port-level checks on the top level
module ecb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input ecb_pkg::out_req_t out_req
);
	`ECB_ASSERT_IMP(a_bits_range, clk, arst_n, out_valid, (out_req.valid_bits != 7'd0) && (out_req.valid_bits <= 7'd64), "valid_bits out of range")
	`ECB_ASSERT_IMP(a_short_last, clk, arst_n, out_valid && out_req.valid_bits != 7'd64, out_req.last_word, "short word not last")
	`ECB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_req), "stalled request changed")
endmodule

bind elementwise_compare_to_bitmask_top ecb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_req(out_req)
);
